// File: rtl/snbf_pkg.sv
// ----------------------------------------------------------------------------
// snbf_pkg: shared types and constants of the sorted nibble Bloom filter
// Widths, digit geometry, request kinds and the control bundle that the
// hash former and the remainder units share.
// ----------------------------------------------------------------------------
`default_nettype none

package snbf_pkg;

  // Hash and digit geometry
  localparam int HASH_W     = 64;
  localparam int DIGIT_W    = 4;
  localparam int DIGITS     = HASH_W / DIGIT_W;
  localparam int DIG_CNT_W  = $clog2(DIGITS);

  // Four hashes, one bit of the nibble each
  localparam int HASH_COUNT = 4;
  localparam int RANK_W     = $clog2(HASH_COUNT);
  localparam int NIBBLE_W   = HASH_COUNT;

  // Store geometry
  localparam int MAX_NIBBLES = 65536;
  localparam int ADDR_W      = $clog2(MAX_NIBBLES);

  // Size register
  localparam int                SIZE_W     = 17;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(65536);

  // Sorting network: five compare-exchange steps
  localparam int SORT_STEPS = 5;
  localparam int SORT_SEL_W = $clog2(SORT_STEPS);

  localparam logic [SORT_SEL_W-1:0] SORT_01 = SORT_SEL_W'(0);
  localparam logic [SORT_SEL_W-1:0] SORT_23 = SORT_SEL_W'(1);
  localparam logic [SORT_SEL_W-1:0] SORT_02 = SORT_SEL_W'(2);
  localparam logic [SORT_SEL_W-1:0] SORT_13 = SORT_SEL_W'(3);
  localparam logic [SORT_SEL_W-1:0] SORT_12 = SORT_SEL_W'(4);

  // Request kinds
  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef logic [HASH_COUNT-1:0][DIGIT_W-1:0] digit_vec_t;
  typedef logic [HASH_COUNT-1:0][SIZE_W-1:0]  rem_vec_t;

  // Datapath control from the sequencer
  typedef struct packed {
    logic                  load;     // capture a new request
    logic                  add;      // one digit of the double-hash sums
    logic                  sort;     // one compare-exchange step
    logic                  shift;    // one digit out, MSB first
    logic [SORT_SEL_W-1:0] sort_sel;
  } hash_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/snbf_ram.sv
// ----------------------------------------------------------------------------
// snbf_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module snbf_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: rtl/snbf_hash.sv
// ----------------------------------------------------------------------------
// snbf_hash: digit-serial double hashing and four-way sort
// Forms h0, h1, h0+h1 and h0+2*h1 one digit a cycle, sorts them with a
// five-step network, then shifts them out MSB digit first.
// ----------------------------------------------------------------------------
`default_nettype none

module snbf_hash (
  input  wire logic                         clk,
  input  wire snbf_pkg::hash_ctrl_t         ctrl,
  input  wire logic [snbf_pkg::HASH_W-1:0]  first_hash,
  input  wire logic [snbf_pkg::HASH_W-1:0]  second_hash,
  output snbf_pkg::digit_vec_t              top_digit
);

  localparam int HW = snbf_pkg::HASH_W;
  localparam int DW = snbf_pkg::DIGIT_W;

  logic [snbf_pkg::HASH_COUNT-1:0][HW-1:0] v;
  logic                                    c2;
  logic                                    c3;

  logic [DW:0]   sum2;
  logic [DW:0]   sum3;
  logic [HW-1:0] cmp_a;
  logic [HW-1:0] cmp_b;
  logic          swap;

  // Serial adders: low digits of h0 and h1 feed both sums
  always_comb begin
    sum2 = {1'b0, v[0][DW-1:0]} + {1'b0, v[1][DW-1:0]} + (DW+1)'(c2);
    sum3 = {1'b0, sum2[DW-1:0]} + {1'b0, v[1][DW-1:0]} + (DW+1)'(c3);
  end

  // Pick the pair of this compare-exchange step
  always_comb begin
    case (ctrl.sort_sel)
      snbf_pkg::SORT_01: begin cmp_a = v[0]; cmp_b = v[1]; end
      snbf_pkg::SORT_23: begin cmp_a = v[2]; cmp_b = v[3]; end
      snbf_pkg::SORT_02: begin cmp_a = v[0]; cmp_b = v[2]; end
      snbf_pkg::SORT_13: begin cmp_a = v[1]; cmp_b = v[3]; end
      snbf_pkg::SORT_12: begin cmp_a = v[1]; cmp_b = v[2]; end
      default:           begin cmp_a = v[0]; cmp_b = v[1]; end
    endcase
    swap = cmp_a > cmp_b;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      v[0] <= first_hash;
      v[1] <= second_hash;
      c2   <= 1'b0;
      c3   <= 1'b0;
    end else if (ctrl.add) begin
      // Rotate the inputs back into place, shift the sums in at the top
      v[0] <= {v[0][DW-1:0], v[0][HW-1:DW]};
      v[1] <= {v[1][DW-1:0], v[1][HW-1:DW]};
      v[2] <= {sum2[DW-1:0], v[2][HW-1:DW]};
      v[3] <= {sum3[DW-1:0], v[3][HW-1:DW]};
      c2   <= sum2[DW];
      c3   <= sum3[DW];
    end else if (ctrl.sort) begin
      if (swap) begin
        case (ctrl.sort_sel)
          snbf_pkg::SORT_01: begin v[0] <= cmp_b; v[1] <= cmp_a; end
          snbf_pkg::SORT_23: begin v[2] <= cmp_b; v[3] <= cmp_a; end
          snbf_pkg::SORT_02: begin v[0] <= cmp_b; v[2] <= cmp_a; end
          snbf_pkg::SORT_13: begin v[1] <= cmp_b; v[3] <= cmp_a; end
          snbf_pkg::SORT_12: begin v[1] <= cmp_b; v[2] <= cmp_a; end
          default: begin end
        endcase
      end
    end else if (ctrl.shift) begin
      for (int k = 0; k < snbf_pkg::HASH_COUNT; k++) begin
        v[k] <= {v[k][HW-DW-1:0], DW'(0)};
      end
    end
  end

  always_comb begin
    for (int k = 0; k < snbf_pkg::HASH_COUNT; k++) begin
      top_digit[k] = v[k][HW-1:HW-DW];
    end
  end

endmodule

`default_nettype wire

// File: rtl/snbf_rem.sv
// ----------------------------------------------------------------------------
// snbf_rem: digit-serial remainder unit
// Takes a dividend MSB digit first and keeps the running remainder
// modulo the divisor on the modulus port, one restoring step per bit.
// ----------------------------------------------------------------------------
`default_nettype none

module snbf_rem (
  input  wire logic                          clk,
  input  wire snbf_pkg::hash_ctrl_t          ctrl,
  input  wire logic [snbf_pkg::DIGIT_W-1:0]  digit,
  input  wire logic [snbf_pkg::SIZE_W-1:0]   modulus,
  output logic      [snbf_pkg::SIZE_W-1:0]   rem
);

  localparam int SW = snbf_pkg::SIZE_W;
  localparam int DW = snbf_pkg::DIGIT_W;

  logic [SW-1:0] rem_next;
  logic [SW:0]   trial;

  // Bring in each bit of the digit; subtract once when it reaches the modulus
  always_comb begin
    rem_next = rem;
    trial    = '0;
    for (int i = 0; i < DW; i++) begin
      trial = {rem_next, digit[DW-1-i]};
      if (trial >= {1'b0, modulus}) begin
        trial = trial - {1'b0, modulus};
      end
      rem_next = trial[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem <= '0;
    end else if (ctrl.shift) begin
      rem <= rem_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sorted_nibble_bloom_filter.sv
// ----------------------------------------------------------------------------
// sorted_nibble_bloom_filter: four-hash Bloom filter over a nibble store
// Double hashing, ascending sort, slot selection by modulo and
// nibble read-modify-write, one request at a time.
// ----------------------------------------------------------------------------
// Each request carries two 64-bit hashes and a kind (add or query). The block
// forms h0, h1, h0+h1 and h0+2*h1 modulo 2^64, sorts them ascending, and the
// hash of rank r picks slot (hash mod size_in_use) of a 64K x 4 store and bit
// r of that slot. An add sets the four bits and answers found=1; a query
// answers 1 only if all four are set. A size_in_use of 0 acts as 1 and one
// above the store depth acts as the depth. After reset the store is cleared
// one slot per clock, so in_ready stays low until all 65536 slots are clear;
// size writes are taken during that time. A request then passes through
// 4-bit digit-serial addition, 5 sort steps, 4-bit digit-serial remainder
// in four parallel units, and a read state and an update state per rank on
// the single read port of the store, then a hand-over state, which waits
// while an earlier answer is still untaken, and idle, where the next
// request is taken. The result sits in an output register, so a new request
// is taken while the previous answer waits for out_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_nibble_bloom_filter (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // size register
  input  wire logic                                cfg_wr_en,
  input  wire logic [snbf_pkg::SIZE_W-1:0]         cfg_wr_data,
  // request channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                kind,
  input  wire logic [snbf_pkg::HASH_W-1:0]         first_hash,
  input  wire logic [snbf_pkg::HASH_W-1:0]         second_hash,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     found
);

  localparam int SW = snbf_pkg::SIZE_W;
  localparam int AW = snbf_pkg::ADDR_W;
  localparam int NW = snbf_pkg::NIBBLE_W;

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_ADD    = 8'b0000_0100,
    ST_SORT   = 8'b0000_1000,
    ST_MOD    = 8'b0001_0000,
    ST_RD     = 8'b0010_0000,
    ST_UPD    = 8'b0100_0000,
    ST_FINISH = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  logic [SW-1:0]                   size_in_use;
  logic [AW-1:0]                   clr_addr;
  logic [snbf_pkg::DIG_CNT_W-1:0]  dig_cnt;
  logic [snbf_pkg::SORT_SEL_W-1:0] sort_cnt;
  logic [snbf_pkg::RANK_W-1:0]     rank;
  logic                            query;
  logic                            all_set;

  logic                  in_take;
  logic                  out_load;
  logic [SW-1:0]         modulus;
  snbf_pkg::hash_ctrl_t  ctrl;
  snbf_pkg::digit_vec_t  top_digit;
  snbf_pkg::rem_vec_t    rem;
  logic [AW-1:0]         slot;
  logic [NW-1:0]         bit_mask;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [NW-1:0]         ram_wdata;
  logic [NW-1:0]         ram_rdata;

  assign in_ready = (state == ST_IDLE);
  assign in_take  = in_valid && in_ready;
  assign out_load = (state == ST_FINISH) && (!out_valid || out_ready);

  // Clamp the size into [1, store depth]
  always_comb begin
    if (size_in_use == '0) begin
      modulus = SW'(1);
    end else if (32'(size_in_use) > snbf_pkg::MAX_NIBBLES) begin
      modulus = SW'(snbf_pkg::MAX_NIBBLES);
    end else begin
      modulus = size_in_use;
    end
  end

  // Size register: written at any time the port enables it
  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= snbf_pkg::SIZE_RESET;
    end else if (cfg_wr_en) begin
      size_in_use <= cfg_wr_data;
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(snbf_pkg::MAX_NIBBLES - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_take) state_next = ST_ADD;
      end
      ST_ADD: begin
        if (dig_cnt == snbf_pkg::DIG_CNT_W'(snbf_pkg::DIGITS - 1)) state_next = ST_SORT;
      end
      ST_SORT: begin
        if (sort_cnt == snbf_pkg::SORT_SEL_W'(snbf_pkg::SORT_STEPS - 1)) state_next = ST_MOD;
      end
      ST_MOD: begin
        if (dig_cnt == snbf_pkg::DIG_CNT_W'(snbf_pkg::DIGITS - 1)) state_next = ST_RD;
      end
      ST_RD: begin
        state_next = ST_UPD;
      end
      ST_UPD: begin
        if (rank == snbf_pkg::RANK_W'(snbf_pkg::HASH_COUNT - 1)) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_RD;
        end
      end
      ST_FINISH: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      dig_cnt  <= '0;
      sort_cnt <= '0;
      rank     <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      // Digit counter wraps after each 16-digit pass
      if (state == ST_ADD || state == ST_MOD) begin
        dig_cnt <= dig_cnt + snbf_pkg::DIG_CNT_W'(1);
      end else begin
        dig_cnt <= '0;
      end
      if (state == ST_SORT) begin
        sort_cnt <= sort_cnt + snbf_pkg::SORT_SEL_W'(1);
      end else begin
        sort_cnt <= '0;
      end
      if (state == ST_UPD) begin
        rank <= rank + snbf_pkg::RANK_W'(1);
      end else if (state == ST_IDLE) begin
        rank <= '0;
      end
    end
  end

  // Request kind and running query answer
  always_ff @(posedge clk) begin
    if (in_take) begin
      query   <= (kind == snbf_pkg::KIND_QUERY);
      all_set <= 1'b1;
    end else if (state == ST_UPD && query && ((ram_rdata & bit_mask) == '0)) begin
      all_set <= 1'b0;
    end
  end

  // Output register: hold the answer until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      found <= query ? all_set : 1'b1;
    end
  end

  // Datapath control
  always_comb begin
    ctrl.load     = in_take;
    ctrl.add      = (state == ST_ADD);
    ctrl.sort     = (state == ST_SORT);
    ctrl.shift    = (state == ST_MOD);
    ctrl.sort_sel = sort_cnt;
  end

  snbf_hash u_hash (
    .clk         (clk),
    .ctrl        (ctrl),
    .first_hash  (first_hash),
    .second_hash (second_hash),
    .top_digit   (top_digit)
  );

  for (genvar k = 0; k < snbf_pkg::HASH_COUNT; k++) begin : g_rem
    snbf_rem u_rem (
      .clk     (clk),
      .ctrl    (ctrl),
      .digit   (top_digit[k]),
      .modulus (modulus),
      .rem     (rem[k])
    );
  end

  // Slot and bit of the current rank
  assign slot     = AW'(rem[rank]);
  assign bit_mask = NW'(1) << rank;

  // Store port: clearing sweep, or the write half of an add
  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = (state == ST_UPD) && !query;
      ram_waddr = slot;
      ram_wdata = ram_rdata | bit_mask;
    end
  end

  snbf_ram #(
    .WIDTH (NW),
    .DEPTH (snbf_pkg::MAX_NIBBLES)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (slot),
    .rd_data (ram_rdata)
  );

  // A request always starts the addition pass
  a_take_starts_add: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == ST_ADD))
    else $error("accepted request did not start the addition pass");

  // Store writes only while clearing or when an add updates a slot
  a_write_source: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == ST_CLEAR) || ((state == ST_UPD) && !query)))
    else $error("unexpected store write");

  // Remainders stay below the modulus once the pass is done
  a_rem_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD) |-> ((rem[0] < modulus) && (rem[1] < modulus) &&
                           (rem[2] < modulus) && (rem[3] < modulus)))
    else $error("remainder out of range");

  // A new answer appears only from the hand-over state
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH))
    else $error("result raised outside hand-over");

endmodule

`default_nettype wire

// File: sim/snbf_checker.sv
// ----------------------------------------------------------------------------
// snbf_checker: result checker for the sorted nibble Bloom filter
// Follows the size register and the request channel, keeps its own copy of
// the nibble store, and compares every answer with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module snbf_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [snbf_pkg::SIZE_W-1:0] cfg_wr_data,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        kind,
  input  logic [snbf_pkg::HASH_W-1:0] first_hash,
  input  logic [snbf_pkg::HASH_W-1:0] second_hash,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        found,
  output int                          fail_count,
  output int                          pending
);

  import snbf_pkg::*;

  logic [NIBBLE_W-1:0] nibbles [MAX_NIBBLES];
  logic [SIZE_W-1:0]   slots_in_use;
  logic                found_q [$];
  logic                want_found;

  // Apply one request to the private store and return the answer it earns.
  function automatic logic filter_lookup(input logic              k,
                                         input logic [HASH_W-1:0] h0,
                                         input logic [HASH_W-1:0] h1);
    logic [HASH_W-1:0] hv [HASH_COUNT];
    logic [HASH_W-1:0] tmp;
    logic [HASH_W-1:0] modulus;
    logic [ADDR_W-1:0] slot;
    logic              all_set;
    hv[0]   = h0;
    hv[1]   = h1;
    hv[2]   = h0 + h1;
    hv[3]   = hv[2] + h1;
    all_set = 1'b1;
    // ascending order; ties land on the same slot, so their order is moot
    for (int i = 0; i < HASH_COUNT - 1; i++) begin
      for (int j = 0; j < HASH_COUNT - 1 - i; j++) begin
        if (hv[j] > hv[j+1]) begin
          tmp     = hv[j];
          hv[j]   = hv[j+1];
          hv[j+1] = tmp;
        end
      end
    end
    modulus = HASH_W'(slots_in_use);
    if (modulus == 0) begin
      modulus = 1;
    end else if (modulus > MAX_NIBBLES) begin
      modulus = MAX_NIBBLES;
    end
    for (int r = 0; r < HASH_COUNT; r++) begin
      slot = ADDR_W'(hv[r] % modulus);
      if (k == KIND_QUERY) begin
        if (!nibbles[slot][r]) all_set = 1'b0;
      end else begin
        nibbles[slot][r] = 1'b1;
      end
    end
    return (k == KIND_QUERY) ? all_set : 1'b1;
  endfunction

  task automatic log_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("%0t ns: %s", $time, what);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (nibbles[i]) nibbles[i] = '0;
      slots_in_use = SIZE_RESET;
      found_q.delete();
    end else begin
      // check the answer first: it can never belong to a request taken now
      if (out_valid && out_ready) begin
        if (found_q.size() == 0) begin
          log_failure($sformatf("answer with no request pending: found=%0b", found));
        end else begin
          want_found = found_q.pop_front();
          if (found !== want_found) begin
            log_failure($sformatf("found mismatch: expected %0b, got %0b",
                                  want_found, found));
          end
        end
      end
      if (cfg_wr_en) slots_in_use = cfg_wr_data;
      if (in_valid && in_ready) begin
        found_q.push_back(filter_lookup(kind, first_hash, second_hash));
      end
    end
    pending = found_q.size();
  end

endmodule

// File: sim/sorted_nibble_bloom_filter_test.sv
// ----------------------------------------------------------------------------
// sorted_nibble_bloom_filter_test: stimulus and verdict for the Bloom filter
// Drives add and query requests across a series of store sizes, with bursty
// requests and a stalling result side; the checker beside the block predicts
// every answer and counts failures.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sorted_nibble_bloom_filter_test;

  import snbf_pkg::*;

  typedef struct packed {
    logic [HASH_W-1:0] h0;
    logic [HASH_W-1:0] h1;
  } hash_pair_t;

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [SIZE_W-1:0] cfg_wr_data;
  logic              in_valid;
  logic              in_ready;
  logic              kind;
  logic [HASH_W-1:0] first_hash;
  logic [HASH_W-1:0] second_hash;
  logic              out_valid;
  logic              out_ready;
  logic              found;
  int                fail_count;
  int                pending;

  // sender pacing: requests in bursts, gaps of up to max_gap cycles between
  int                burst_left;
  int                max_gap;

  // keys already added, so queries can hit as well as miss
  hash_pair_t        added_keys [$];

  // sizes of the random phases; the last entry is replaced by a random size
  logic [SIZE_W-1:0] phase_sizes [10] = '{
    SIZE_W'(131071), SIZE_W'(65535), SIZE_W'(4099), SIZE_W'(257), SIZE_W'(16),
    SIZE_W'(1), SIZE_W'(0), SIZE_W'(65537), SIZE_W'(2), SIZE_W'(1)
  };

  sorted_nibble_bloom_filter i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .first_hash  (first_hash),
    .second_hash (second_hash),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found)
  );

  snbf_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .first_hash  (first_hash),
    .second_hash (second_hash),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly random hashes, with the all-zero, all-one and one-hot corners mixed in.
  function automatic logic [HASH_W-1:0] rand_hash();
    logic [HASH_W-1:0] h;
    case ($urandom_range(0, 15))
      0:       h = '0;
      1:       h = '1;
      2:       h = HASH_W'(1) << $urandom_range(0, HASH_W - 1);
      default: h = {$urandom, $urandom};
    endcase
    return h;
  endfunction

  // Present one request and hold it until the block takes it. Call at a
  // falling edge; returns at the falling edge after the acceptance.
  task automatic send_request(input logic              k,
                              input logic [HASH_W-1:0] h0,
                              input logic [HASH_W-1:0] h1);
    int gap;
    if (burst_left == 0) begin
      // start a new burst, after an idle gap when one is drawn
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 6);
    end
    burst_left--;
    in_valid    = 1'b1;
    kind        = k;
    first_hash  = h0;
    second_hash = h1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    // drop valid at the end of a burst so the taken request is not repeated
    if (burst_left == 0) in_valid = 1'b0;
  endtask

  // Drop valid and hold until every predicted answer has come back.
  task automatic drain_requests();
    in_valid   = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] value);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  // Result side: ready in stretches of random length, stalls between them,
  // and now and then a long stretch with no stall at all.
  initial begin
    out_ready = 1'b0;
    forever begin
      if ($urandom_range(0, 7) == 0) begin
        out_ready = 1'b1;
        repeat (400) @(negedge clk);
      end else begin
        out_ready = 1'b1;
        repeat ($urandom_range(1, 40)) @(negedge clk);
        out_ready = 1'b0;
        repeat ($urandom_range(1, 80)) @(negedge clk);
      end
    end
  end

  // Main stimulus: directed corners at the reset size, then random phases.
  initial begin
    hash_pair_t key;
    int         pick;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    kind        = KIND_ADD;
    first_hash  = '0;
    second_hash = '0;
    burst_left  = 0;
    max_gap     = 60;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // Directed part at the reset size. The block clears its store first, so
    // the first request waits out the clearing pass on in_ready.
    send_request(KIND_QUERY, '0, '0);   // empty store must miss
    send_request(KIND_ADD,   '0, '0);   // all four hashes hit slot 0
    send_request(KIND_QUERY, '0, '0);
    send_request(KIND_QUERY, '1, '1);   // top slots, still empty
    send_request(KIND_ADD,   '1, '1);   // sums wrap below 2^64
    send_request(KIND_QUERY, '1, '1);
    send_request(KIND_ADD,   HASH_W'(1), '1);   // h0+h1 wraps to zero
    send_request(KIND_QUERY, HASH_W'(1), '1);
    send_request(KIND_QUERY, '0, HASH_W'(1));   // only some bits set
    send_request(KIND_ADD,   HASH_W'(5), HASH_W'(5));   // equal hashes
    send_request(KIND_QUERY, HASH_W'(5), HASH_W'(5));
    send_request(KIND_ADD,   64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    send_request(KIND_QUERY, 64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000);
    send_request(KIND_ADD,   64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_request(KIND_QUERY, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(KIND_QUERY, 64'hFFFF_FFFF_FFFF_0000, 64'h0000_0000_0001_0000);
    send_request(KIND_QUERY, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);

    // Random phases. Each starts idle with a new size; the store is not
    // cleared, so later phases see the old bits through the new modulus.
    for (int p = 0; p < 10; p++) begin
      drain_requests();
      if (p == 9) begin
        write_size(SIZE_W'($urandom_range(1, MAX_NIBBLES)));
      end else begin
        write_size(phase_sizes[p]);
      end
      // every third phase runs the sender flat out
      max_gap = (p % 3 == 1) ? 0 : 60;
      for (int n = 0; n < 50; n++) begin
        pick = $urandom_range(0, 9);
        if (pick <= 3) begin
          // add a fresh key and remember it
          key.h0 = rand_hash();
          key.h1 = rand_hash();
          added_keys.push_back(key);
          if (added_keys.size() > 48) void'(added_keys.pop_front());
          send_request(KIND_ADD, key.h0, key.h1);
        end else if (pick <= 6 && added_keys.size() > 0) begin
          // query a key that was added, a hit unless the size moved since
          key = added_keys[$urandom_range(0, added_keys.size() - 1)];
          send_request(KIND_QUERY, key.h0, key.h1);
        end else if (pick == 9) begin
          // related hashes: equal, summing to zero, or second hash zero
          key.h0 = rand_hash();
          case ($urandom_range(0, 2))
            0:       key.h1 = key.h0;
            1:       key.h1 = -key.h0;
            default: key.h1 = '0;
          endcase
          send_request(($urandom_range(0, 1) != 0) ? KIND_QUERY : KIND_ADD,
                       key.h0, key.h1);
        end else begin
          // query a fresh key, mostly a miss on large sizes
          send_request(KIND_QUERY, rand_hash(), rand_hash());
        end
      end
    end

    // Wait for the last answers, then give the block time to show strays.
    drain_requests();
    repeat (100) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop: several times the slowest correct run, clearing pass included.
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: files.f
rtl/snbf_pkg.sv
rtl/snbf_ram.sv
rtl/snbf_hash.sv
rtl/snbf_rem.sv
rtl/sorted_nibble_bloom_filter.sv
sim/snbf_checker.sv
sim/sorted_nibble_bloom_filter_test.sv
